[sv/sau_pkg.sv]
// ----------------------------------------------------------------------------
// sau_pkg
// Shared types and codes of the stack arithmetic unit: request and result
// payloads, opcodes, status codes and controller states.
// ----------------------------------------------------------------------------
package sau_pkg;

    localparam int unsigned DataWidth   = 32;
    localparam int unsigned ActionWidth = 3;
    localparam int unsigned StatusWidth = 2;
    localparam int unsigned DepthWidth  = 7;

    typedef enum logic [ActionWidth-1:0] {
        ACT_PUSH = 3'd0,
        ACT_NOP  = 3'd1,
        ACT_SWAP = 3'd2,
        ACT_ADD  = 3'd3,
        ACT_SUB  = 3'd4,
        ACT_DIV  = 3'd5
    } t_action;

    typedef enum logic [StatusWidth-1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ActionWidth-1:0]     action;
        logic signed [DataWidth-1:0] push_value;
    } t_req;

    typedef struct packed {
        logic [StatusWidth-1:0]      status;
        logic signed [DataWidth-1:0] top_value;
        logic [DepthWidth-1:0]       stack_depth;
    } t_res;

endpackage

[sv/stack_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// stack_arithmetic_unit
// Operand stack of 32-bit signed integers with push, swap, add, sub and
// truncating divide, one opcode per request and one result per request.
// ----------------------------------------------------------------------------
// Each request runs to completion before the next one is taken. Push, nop,
// swap, add and sub pass through accept and read, execute and commit; div
// also waits in the divide state between execute and commit. The divider
// is started from the execute state, produces one quotient bit per cycle
// until all 32 are done, then signals done and the controller captures
// the quotient. A result that cannot leave holds the block in the commit
// state. The top entry is held in a register and the entries below it
// live in a single-port-write, single-port-read memory, so every opcode
// needs at most one memory read (the second entry) and one memory write.
// The finished result sits in an output register, so a new request can be
// accepted while it waits; a second result waits in the commit state until
// the first is taken. The memory is not cleared after reset; no entry's
// data is used before it is written. Error cases (short stack, zero
// divisor, full stack) report a status code and leave the stack untouched.
// Opcodes 6 and 7 act as nop.
// ----------------------------------------------------------------------------
module stack_arithmetic_unit import sau_pkg::*; #(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_res o_out_res
);

    // Address width of the memory, and count width that can hold the depth.
    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    // Controller state and architectural stack state.
    t_state               r_state, n_state;
    logic [CW-1:0]        r_count;
    logic [DataWidth-1:0] r_top;

    // The request being executed.
    logic [ActionWidth-1:0] r_action;
    logic [DataWidth-1:0]   r_value;

    // Pending outcome, committed in the done state.
    logic [StatusWidth-1:0] r_status, n_status;
    logic [DataWidth-1:0]   r_new_top, n_new_top;
    logic [CW-1:0]          r_new_count, n_new_count;
    logic                   r_wr_en, n_wr_en;
    logic [AW-1:0]          r_wr_addr, n_wr_addr;
    logic [DataWidth-1:0]   r_wr_data, n_wr_data;

    // Output register.
    logic r_out_valid;
    t_res r_out_res;

    logic                 in_accept;
    logic                 out_free;
    logic                 commit;
    logic [CW-1:0]        cnt_m1;
    logic [CW-1:0]        cnt_m2;
    logic                 short_stack;
    logic [DataWidth-1:0] second;
    logic                 mem_wr_en;
    logic                 div_start;
    logic                 div_done;
    logic [DataWidth-1:0] div_quo;
    logic [CW+DepthWidth-1:0] depth_ext;

    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign commit      = (r_state == S_DONE) && out_free;
    assign cnt_m1      = r_count - CW'(1);
    assign cnt_m2      = r_count - CW'(2);
    assign short_stack = r_count < CW'(2);
    assign mem_wr_en   = commit && r_wr_en;

    // The memory holds every entry except the top one. The read of the second
    // entry is issued at acceptance; its data is ready in the execute state.
    // Writes only happen at commit, always at an edge earlier than the read
    // of the following request, so no forwarding is needed.
    sau_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (r_wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (cnt_m2[AW-1:0]),
        .o_rd_data (second)
    );

    sau_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (second),
        .i_divisor  (r_top),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count     <= r_new_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action <= i_in_req.action;
            r_value  <= i_in_req.push_value;
        end
        r_status    <= n_status;
        r_new_top   <= n_new_top;
        r_new_count <= n_new_count;
        r_wr_en     <= n_wr_en;
        r_wr_addr   <= n_wr_addr;
        r_wr_data   <= n_wr_data;
        if (commit) begin
            r_top                 <= r_new_top;
            r_out_res.status      <= r_status;
            r_out_res.top_value   <= (r_new_count == '0) ? '0 : r_new_top;
            r_out_res.stack_depth <= depth_ext[DepthWidth-1:0];
        end
    end

    // The reported depth is the count taken modulo 128.
    assign depth_ext = {{DepthWidth{1'b0}}, r_new_count};

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_new_top   = r_new_top;
        n_new_count = r_new_count;
        n_wr_en     = r_wr_en;
        n_wr_addr   = r_wr_addr;
        n_wr_data   = r_wr_data;
        o_in_ready  = 1'b0;
        div_start   = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                // Default outcome: state unchanged, status ok.
                n_state     = S_DONE;
                n_status    = ST_OK;
                n_new_top   = r_top;
                n_new_count = r_count;
                n_wr_en     = 1'b0;
                n_wr_addr   = cnt_m2[AW-1:0];
                n_wr_data   = r_top;
                case (r_action)
                    ACT_PUSH: begin
                        if (r_count == CW'(STACK_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            // The old top moves down into the memory.
                            n_wr_en     = (r_count != '0);
                            n_wr_addr   = cnt_m1[AW-1:0];
                            n_new_top   = r_value;
                            n_new_count = r_count + CW'(1);
                        end
                    end
                    ACT_SWAP: begin
                        if (short_stack) begin
                            n_status = ST_SHORT;
                        end else begin
                            n_wr_en   = 1'b1;
                            n_new_top = second;
                        end
                    end
                    ACT_ADD, ACT_SUB: begin
                        if (short_stack) begin
                            n_status = ST_SHORT;
                        end else begin
                            n_new_top   = (r_action == ACT_ADD) ? (second + r_top)
                                                                : (second - r_top);
                            n_new_count = cnt_m1;
                        end
                    end
                    ACT_DIV: begin
                        if (short_stack) begin
                            n_status = ST_SHORT;
                        end else if (r_top == '0) begin
                            n_status = ST_DIVZERO;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                    default: begin
                        // Nop and unused opcodes leave everything as it is.
                    end
                endcase
            end

            S_DIV: begin
                if (div_done) begin
                    n_new_top   = div_quo;
                    n_new_count = cnt_m1;
                    n_state     = S_DONE;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

`ifndef SYNTH
    // The entry count never goes past the stack depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("entry count beyond stack depth");

    // A request that ends in an error leaves the count unchanged.
    a_error_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (r_status != ST_OK)) |-> (r_new_count == r_count))
        else $error("error result changed the entry count");

    // The divider only finishes while the controller waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    // Every commit produces a valid result on the next cycle.
    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_out_valid)
        else $error("committed result not presented");
`endif

endmodule

[sv/sau_stack_mem.sv]
// ----------------------------------------------------------------------------
// sau_stack_mem
// Stack entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sau_stack_mem import sau_pkg::*; #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [DataWidth-1:0] i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [DataWidth-1:0] o_rd_data
);

    logic [DataWidth-1:0] r_mem [DEPTH];
    logic [DataWidth-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/sau_divider.sv]
// ----------------------------------------------------------------------------
// sau_divider
// Iterative signed 32-bit divider, truncating toward zero, one quotient bit
// per cycle. The quotient is valid while o_done is high.
// ----------------------------------------------------------------------------
module sau_divider import sau_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [DataWidth-1:0] i_dividend,
    input  logic signed [DataWidth-1:0] i_divisor,
    output logic                        o_done,
    output logic signed [DataWidth-1:0] o_quotient
);

    localparam int unsigned StepWidth = $clog2(DataWidth);

    logic                   r_busy;
    logic                   r_done;
    logic [StepWidth-1:0]   r_step;
    logic                   r_neg;
    logic [DataWidth-1:0]   r_den;
    logic [DataWidth-1:0]   r_rem;
    logic [DataWidth-1:0]   r_quo;

    logic [DataWidth:0]     trial;
    logic [DataWidth-1:0]   mag_num;
    logic [DataWidth-1:0]   mag_den;

    assign mag_num = i_dividend[DataWidth-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign mag_den = i_divisor[DataWidth-1]  ? (~i_divisor + 1'b1)  : i_divisor;

    // Shift in the next dividend bit and try to subtract the divisor.
    assign trial = {r_rem, r_quo[DataWidth-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == StepWidth'(DataWidth - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DataWidth-1] ^ i_divisor[DataWidth-1];
            r_den <= mag_den;
            r_rem <= '0;
            r_quo <= mag_num;
        end else if (r_busy) begin
            if (!trial[DataWidth]) begin
                r_rem <= trial[DataWidth-1:0];
            end else begin
                r_rem <= {r_rem[DataWidth-2:0], r_quo[DataWidth-1]};
            end
            r_quo <= {r_quo[DataWidth-2:0], ~trial[DataWidth]};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule
